/* src/hsfc_pkg.sv */
// Package: constants and the command type for the half/single converter.
`default_nettype none
package hsfc_pkg;

  typedef enum logic {
    CMD_S2H = 1'b0,
    CMD_H2S = 1'b1
  } cmd_e;

  localparam logic [30:0] SGL_OVF_LIMIT = 31'h477F_EFFF;
  localparam logic [30:0] SGL_UNF_LIMIT = 31'h3300_0001;
  localparam logic [30:0] SGL_INF_MAG   = 31'h7F80_0000;
  localparam logic [14:0] HALF_QNAN     = 15'h7E00;
  localparam logic [14:0] HALF_INF      = 15'h7C00;
  localparam logic [12:0] HALF_TIE      = 13'h1000;
  localparam logic [7:0]  SUBN_EXP_START = 8'd113;
  localparam logic [7:0]  EXP_REBIAS     = 8'd112;
  localparam logic [22:0] SGL_QUIET      = 23'h40_0000;

endpackage
`default_nettype wire

/* src/hsfc_s2h.sv */
// Single to half conversion datapath with round to nearest even.
`default_nettype none
module hsfc_s2h (
  input  wire logic [31:0] single_i,
  output logic      [15:0] half_o
);

  logic        sgn;
  logic [30:0] mag;
  logic [7:0]  e;
  logic [23:0] mfull;
  logic [4:0]  sh;
  logic [10:0] q_sub;
  logic [23:0] rem_sub;
  logic [23:0] tie_sub;
  logic [10:0] q_sub_r;
  logic [9:0]  q_nrm;
  logic [12:0] rem_nrm;
  logic [5:0]  he;
  logic        up_nrm;
  logic [15:0] nrm_sum;

  always_comb begin
    sgn     = single_i[31];
    mag     = single_i[30:0];
    e       = mag[30:23];
    mfull   = {1'b1, mag[22:0]};
    sh      = 5'(8'd126 - e);
    q_sub   = 11'(mfull >> sh);
    rem_sub = mfull & ((24'd1 << sh) - 24'd1);
    tie_sub = 24'd1 << (sh - 5'd1);
    q_sub_r = q_sub + 11'((rem_sub > tie_sub) || (rem_sub == tie_sub && q_sub[0]));
    q_nrm   = mag[22:13];
    rem_nrm = mag[12:0];
    up_nrm  = (rem_nrm > hsfc_pkg::HALF_TIE) || (rem_nrm == hsfc_pkg::HALF_TIE && q_nrm[0]);
    he      = 6'(e - hsfc_pkg::EXP_REBIAS);
    // carry out of the mantissa rolls into the exponent
    nrm_sum = {he, q_nrm} + 16'(up_nrm);
    if (mag >= hsfc_pkg::SGL_INF_MAG) begin
      half_o = {sgn, (mag == hsfc_pkg::SGL_INF_MAG) ? hsfc_pkg::HALF_INF : hsfc_pkg::HALF_QNAN};
    end else if (mag > hsfc_pkg::SGL_OVF_LIMIT) begin
      half_o = {sgn, hsfc_pkg::HALF_INF};
    end else if (mag < hsfc_pkg::SGL_UNF_LIMIT) begin
      half_o = {sgn, 15'd0};
    end else if (e < hsfc_pkg::SUBN_EXP_START) begin
      half_o = {sgn, 4'd0, q_sub_r};
    end else if (nrm_sum[15:10] >= 6'd31) begin
      half_o = {sgn, hsfc_pkg::HALF_INF};
    end else begin
      half_o = {sgn, nrm_sum[14:0]};
    end
  end

endmodule
`default_nettype wire

/* src/hsfc_h2s.sv */
// Half to single conversion datapath with subnormal normalization.
`default_nettype none
module hsfc_h2s (
  input  wire logic [15:0] half_i,
  output logic      [31:0] single_o
);

  logic       sgn;
  logic [4:0] e;
  logic [9:0] m;
  logic [3:0] lz;
  logic [9:0] m_norm;
  logic [7:0] e_norm;

  always_comb begin
    sgn = half_i[15];
    e   = half_i[14:10];
    m   = half_i[9:0];
    lz  = 4'd0;
    for (int i = 0; i < 10; i++) begin
      if (m[i]) lz = 4'(9 - i);
    end
    m_norm = 10'(m << (lz + 4'd1));
    e_norm = hsfc_pkg::SUBN_EXP_START - 8'(lz) - 8'd1;
    if (e == 5'd0) begin
      single_o = (m == 10'd0) ? {sgn, 31'd0} : {sgn, e_norm, m_norm, 13'd0};
    end else if (e == 5'h1F) begin
      single_o = {sgn, 8'hFF, {m, 13'd0} | ((m != 10'd0) ? hsfc_pkg::SGL_QUIET : 23'd0)};
    end else begin
      single_o = {sgn, 8'(e) + hsfc_pkg::EXP_REBIAS, m, 13'd0};
    end
  end

endmodule
`default_nettype wire

/* src/half_single_float_converter_top.sv */
// Top level: registered single/half float converter with a stream interface.
`default_nettype none
// One operand per cycle unless the output stalls: the input register feeds
// the conversion logic, which loads an output register. A request is taken
// whenever either register is empty or the output is being drained.
module half_single_float_converter_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,  // [31:0] operand_bits
  input  wire logic        s_axis_tuser,  // [0] cmd
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [31:0] m_axis_tdata   // [31:0] result_bits
);

  logic        in_vld_q;
  logic        in_cmd_q;
  logic [31:0] in_op_q;
  logic        out_vld_q;
  logic [31:0] out_q;
  logic        adv;
  logic [15:0] s2h_res;
  logic [31:0] h2s_res;

  hsfc_s2h u_s2h (.single_i(in_op_q), .half_o(s2h_res));
  hsfc_h2s u_h2s (.half_i(in_op_q[15:0]), .single_o(h2s_res));

  assign adv           = !out_vld_q || m_axis_tready;
  assign s_axis_tready = adv || !in_vld_q;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (s_axis_tready) in_vld_q <= s_axis_tvalid;
      if (adv) out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_cmd_q <= s_axis_tuser;
      in_op_q  <= s_axis_tdata;
    end
    if (adv && in_vld_q) begin
      out_q <= (in_cmd_q == hsfc_pkg::CMD_H2S) ? h2s_res : {16'd0, s2h_res};
    end
  end

  // hold a stalled result
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !m_axis_tready |=> out_vld_q && $stable(out_q))
    else $error("result changed while stalled");
  // an accepted request reaches the output stage next time it can move
  a_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && adv |=> out_vld_q)
    else $error("request lost");
  // half results keep upper bits clear
  a_upper: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && adv && in_cmd_q == hsfc_pkg::CMD_S2H |=> out_q[31:16] == 16'd0)
    else $error("upper bits set on half result");

endmodule
`default_nettype wire
